// ----- src/dmtc_pkg.sv -----
// ============================================================================
// dmtc_pkg
// Types and constants shared by the dual mode turn controller modules.
// ============================================================================
package dmtc_pkg;

    localparam int GAIN_FRACTION_BITS = 8;
    localparam int ERR_W              = 40;
    localparam int DELTA_W            = ERR_W + 1;
    localparam int SUM_W              = 24;
    localparam int ACC_W              = 60;
    localparam int MUL_A_W            = 25;
    localparam int MUL_B_W            = 17;
    localparam int PROD_W             = MUL_A_W + MUL_B_W;
    localparam int SPLIT              = 24;
    localparam int DRIVE_SHIFT        = 8 + GAIN_FRACTION_BITS;
    localparam int STEP_W             = 3;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 16;

    // multiply steps
    localparam logic [STEP_W-1:0] STEP_P_LO = 3'd0;
    localparam logic [STEP_W-1:0] STEP_P_HI = 3'd1;
    localparam logic [STEP_W-1:0] STEP_D_LO = 3'd2;
    localparam logic [STEP_W-1:0] STEP_D_HI = 3'd3;
    localparam logic [STEP_W-1:0] STEP_I    = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_KP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_KD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_KI    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_KP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_KD    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_SCALE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIVE  = 3'd6;

    typedef struct packed {
        logic [15:0] rate_kp;
        logic [15:0] rate_kd;
        logic [15:0] rate_ki;
        logic [15:0] hold_kp;
        logic [15:0] hold_kd;
        logic [7:0]  rate_scale;
        logic [7:0]  max_drive;
    } cfg_t;

    typedef struct packed {
        logic              load_in;
        logic              prep;
        logic              calc_err;
        logic              calc_term;
        logic              mul_en;
        logic [STEP_W-1:0] step;
        logic              round;
        logic              out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic holding;
    } dp_status_t;

endpackage

// ----- src/dual_mode_turn_controller_unit.sv -----
// ============================================================================
// dual_mode_turn_controller_unit
// Rate PID / heading hold PD turn controller with clamped drive output.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid/tready             tdata: turn_cmd, wheel_difference
//   m_axis    out        tvalid/tready             tdata: turn_drive; tuser: holding
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// A result is valid once its word has passed the sequence; in rate mode the five
// passes (four in hold mode) through the shared 25x17 multiplier set it.
// Input is taken again in the cycle after the result is loaded, so a new word
// is not accepted while the last one is still in progress.
// A result waiting on m_axis does not block the next accept; it stalls only
// the final load. Reset clears state and loads the default gains.
// ============================================================================
module dual_mode_turn_controller_unit
    import dmtc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [47:0]            s_axis_tdata,  // turn_cmd[9:0], wheel_difference[41:10]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [15:0]            m_axis_tdata,  // turn_drive[8:0]
    output logic [0:0]             m_axis_tuser,  // holding[0]
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    ctl_cmd_t   cmd;
    dp_status_t status;
    logic [8:0] turn_drive;
    logic       holding;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_kp    <= 16'd1587;
            cfg_reg.rate_kd    <= 16'd384;
            cfg_reg.rate_ki    <= 16'd0;
            cfg_reg.hold_kp    <= 16'd1024;
            cfg_reg.hold_kd    <= 16'd2048;
            cfg_reg.rate_scale <= 8'd25;
            cfg_reg.max_drive  <= 8'd150;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATE_KP:    cfg_reg.rate_kp    <= cfg_data;
                REG_RATE_KD:    cfg_reg.rate_kd    <= cfg_data;
                REG_RATE_KI:    cfg_reg.rate_ki    <= cfg_data;
                REG_HOLD_KP:    cfg_reg.hold_kp    <= cfg_data;
                REG_HOLD_KD:    cfg_reg.hold_kd    <= cfg_data;
                REG_RATE_SCALE: cfg_reg.rate_scale <= cfg_data[7:0];
                REG_MAX_DRIVE:  cfg_reg.max_drive  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    dmtc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dmtc_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg_reg),
        .turn_cmd         ($signed(s_axis_tdata[9:0])),
        .wheel_difference (s_axis_tdata[41:10]),
        .status           (status),
        .turn_drive       (turn_drive),
        .holding          (holding)
    );

    assign m_axis_tdata = {7'd0, turn_drive};
    assign m_axis_tuser = holding;

endmodule

// ----- src/dmtc_ctrl.sv -----
// ============================================================================
// dmtc_ctrl
// Sequencer for one control tick: error, terms, multiply steps, output.
// ============================================================================
module dmtc_ctrl
    import dmtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ERR   = 3'd2;
    localparam logic [2:0] S_TERM  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_ROUND = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] last_step;
    logic              out_valid_reg, out_valid_next;

    assign last_step = status.holding ? STEP_D_HI : STEP_I;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_TERM;
            end
            S_TERM:
            begin
                cmd.calc_term = 1'b1;
                step_next     = STEP_P_LO;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = step_reg;
                if (step_reg == last_step)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_P_LO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/dmtc_dpath.sv -----
// ============================================================================
// dmtc_dpath
// Error, integral and derivative terms, shared multiplier and output clamp.
// ============================================================================
module dmtc_dpath
    import dmtc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    input  cfg_t              cfg,
    input  logic signed [9:0] turn_cmd,
    input  logic [31:0]       wheel_difference,
    output dp_status_t        status,
    output logic [8:0]        turn_drive,
    output logic              holding
);

    logic signed [9:0]             cmd_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [COUNT_WIDTH-1:0] prev_diff_reg;
    logic signed [COUNT_WIDTH-1:0] held_reg;
    logic signed [COUNT_WIDTH-1:0] diff_reg;
    logic signed [18:0]            target_reg;
    logic                          hold_reg;
    logic signed [ERR_W-1:0]       err_reg, err_next;
    logic signed [ERR_W-1:0]       prev_err_reg;
    logic signed [DELTA_W-1:0]     delta_reg;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          prod_hi_reg;
    logic                          prod_vld_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       q_reg;
    logic [8:0]                    drive_reg, drive_next;
    logic                          holding_reg;

    logic signed [41:0]            diff_sh;
    logic signed [41:0]            err_raw;
    logic signed [DELTA_W-1:0]     err_ext;
    logic signed [SUM_W:0]         sum_raw;
    logic signed [DELTA_W-1:0]     mul_src;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic [15:0]                   gain;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       acc_bias;
    logic signed [ACC_W-1:0]       lim;
    logic signed [ACC_W-1:0]       neg_lim;

    assign status.holding = hold_reg;
    assign turn_drive     = drive_reg;
    assign holding        = holding_reg;

    // error in Q8, saturated to ERR_W bits
    assign diff_sh = 42'(diff_reg) <<< 8;
    assign err_raw = hold_reg ? diff_sh : (42'(target_reg) - diff_sh);

    always_comb
    begin
        if ((err_raw[41:ERR_W-1] == '0) || (err_raw[41:ERR_W-1] == '1))
        begin
            err_next = err_raw[ERR_W-1:0];
        end
        else if (err_raw[41])
        begin
            err_next = {1'b1, {(ERR_W-1){1'b0}}};
        end
        else
        begin
            err_next = {1'b0, {(ERR_W-1){1'b1}}};
        end
    end

    assign err_ext = DELTA_W'(err_reg);
    assign sum_raw = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(err_reg);

    always_comb
    begin
        if (hold_reg)
        begin
            sum_next = '0;
        end
        else if (sum_raw[SUM_W] == sum_raw[SUM_W-1] && !(
                 (err_reg[ERR_W-1:SUM_W] != '0) && (err_reg[ERR_W-1:SUM_W] != '1)))
        begin
            sum_next = sum_raw[SUM_W-1:0];
        end
        else if (err_reg[ERR_W-1])
        begin
            sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_next = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // multiply operand select
    always_comb
    begin
        mul_src = err_ext;
        gain    = hold_reg ? cfg.hold_kp : cfg.rate_kp;
        mul_a   = '0;
        unique case (cmd.step)
            STEP_P_LO, STEP_P_HI:
            begin
                mul_src = err_ext;
                gain    = hold_reg ? cfg.hold_kp : cfg.rate_kp;
            end
            STEP_D_LO, STEP_D_HI:
            begin
                mul_src = delta_reg;
                gain    = hold_reg ? cfg.hold_kd : cfg.rate_kd;
            end
            default:
            begin
                mul_src = err_ext;
                gain    = cfg.rate_ki;
            end
        endcase
        unique case (cmd.step)
            STEP_P_LO, STEP_D_LO:
            begin
                mul_a = $signed({1'b0, mul_src[SPLIT-1:0]});
            end
            STEP_P_HI, STEP_D_HI:
            begin
                mul_a = MUL_A_W'($signed(mul_src[DELTA_W-1:SPLIT]));
            end
            default:
            begin
                mul_a = MUL_A_W'(sum_reg);
            end
        endcase
    end

    assign mul_b    = $signed({1'b0, gain});
    assign prod_ext = prod_hi_reg ? (ACC_W'(prod_reg) <<< SPLIT) : ACC_W'(prod_reg);
    assign acc_bias = acc_reg[ACC_W-1] ? ACC_W'((1 << DRIVE_SHIFT) - 1) : '0;

    // clamp to +-max_drive
    assign lim     = $signed({{(ACC_W-8){1'b0}}, cfg.max_drive});
    assign neg_lim = -lim;

    always_comb
    begin
        if (q_reg > lim)
        begin
            drive_next = lim[8:0];
        end
        else if (q_reg < neg_lim)
        begin
            drive_next = neg_lim[8:0];
        end
        else
        begin
            drive_next = q_reg[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_diff_reg <= '0;
            held_reg      <= '0;
            prev_err_reg  <= '0;
            sum_reg       <= '0;
            hold_reg      <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
            if (cmd.prep)
            begin
                hold_reg <= (cmd_reg == '0);
            end
            if (cmd.calc_term)
            begin
                sum_reg       <= sum_next;
                prev_err_reg  <= err_reg;
                prev_diff_reg <= count_reg;
                if (!hold_reg)
                begin
                    held_reg <= count_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg   <= turn_cmd;
            count_reg <= wheel_difference[COUNT_WIDTH-1:0];
        end
        if (cmd.prep)
        begin
            diff_reg   <= (cmd_reg == '0) ? (held_reg - count_reg)
                                          : (count_reg - prev_diff_reg);
            target_reg <= 19'(cmd_reg) * 19'($signed({1'b0, cfg.rate_scale}));
        end
        if (cmd.calc_err)
        begin
            err_reg <= err_next;
        end
        if (cmd.calc_term)
        begin
            delta_reg <= err_ext - DELTA_W'(prev_err_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg    <= mul_a * mul_b;
            prod_hi_reg <= (cmd.step == STEP_P_HI) || (cmd.step == STEP_D_HI);
        end
        if (cmd.calc_term)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        if (cmd.round)
        begin
            q_reg <= (acc_reg + acc_bias) >>> DRIVE_SHIFT;
        end
        if (cmd.out_load)
        begin
            drive_reg   <= drive_next;
            holding_reg <= hold_reg;
        end
    end

endmodule
